// ----- sv/sle_pkg.sv -----
// Shared types and codes for the sorted list engine.
package sle_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam int unsigned VALUE_W = 32;

  typedef struct packed {
    logic lt;  // stored entry is below the key
    logic eq;  // stored entry equals the key
  } cmp_t;

endpackage

// ----- sv/sle_cmp.sv -----
// Shared signed comparator used by the scan sequencer.
module sle_cmp (
  input  logic signed [sle_pkg::VALUE_W-1:0] entry,
  input  logic signed [sle_pkg::VALUE_W-1:0] key,
  output sle_pkg::cmp_t                      res
);

  always_comb begin
    res.lt = (entry < key);
    res.eq = (entry == key);
  end

endmodule

// ----- sv/sorted_list_engine_top.sv -----
// Sorted list engine: sequencer, entry memory and shared comparator.
// Per word, the scan compares entries from position 0 until one is not below the value; an
// insert then shifts the larger entries up a place and writes the value, a delete shifts the
// later entries down a place. Full-store inserts and unused opcodes skip the scan.
// The result turns valid as the block turns ready for the next word; a stalled result
// holds the sequencer. Scan and shifts share the one read port. One word is in flight at a
// time. Synchronous active-high reset empties the list, idles the sequencer, drops m_tvalid.
module sorted_list_engine_top #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] position, [8:4] entry_count, rest zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE     = CW'(1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_CMP = 3'd2;
  localparam logic [2:0] S_DECIDE   = 3'd3;
  localparam logic [2:0] S_SH_RD    = 3'd4;
  localparam logic [2:0] S_SH_WR    = 3'd5;
  localparam logic [2:0] S_PUT      = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]                           state;
  logic [1:0]                           op;
  logic signed [sle_pkg::VALUE_W-1:0]   val;
  logic [CW-1:0]                        i;      // scan index, then the target position
  logic [CW-1:0]                        j;      // shift pointer
  logic [CW-1:0]                        count;
  logic                                 found;
  logic [1:0]                           status;
  logic [3:0]                           out_pos;
  logic [4:0]                           out_cnt;

  // Entry memory with one registered read port and one write port.
  logic signed [sle_pkg::VALUE_W-1:0]   mem [DEPTH];
  logic signed [sle_pkg::VALUE_W-1:0]   rdata;
  logic [AW-1:0]                        rd_addr;
  logic                                 we;
  logic [AW-1:0]                        wa;
  logic signed [sle_pkg::VALUE_W-1:0]   wd;

  sle_pkg::cmp_t                        cmp;
  logic [CW-1:0]                        jm1;
  logic [CW-1:0]                        jp1;
  logic [31:0]                          pos_wide;
  logic [31:0]                          cnt_wide;

  assign jm1 = j - ONE;
  assign jp1 = j + ONE;

  sle_cmp u_cmp (
    .entry (rdata),
    .key   (val),
    .res   (cmp)
  );

  // The scan reads the entry at the scan index; shifts read the neighbor of the
  // pointer, one place down for an insert and one place up for a delete.
  always_comb begin
    if (state == S_SCAN_RD) begin
      rd_addr = i[AW-1:0];
    end else if (op == sle_pkg::OP_INSERT) begin
      rd_addr = jm1[AW-1:0];
    end else begin
      rd_addr = jp1[AW-1:0];
    end
  end

  always_comb begin
    we = 1'b0;
    wa = j[AW-1:0];
    wd = rdata;
    if (state == S_SH_WR) begin
      we = 1'b1;
    end else if (state == S_PUT) begin
      we = 1'b1;
      wa = i[AW-1:0];
      wd = val;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (we) begin
      mem[wa] <= wd;
    end
  end

  assign s_tready = (state == S_IDLE);

  // Position is reported only for a successful operation, masked to its field.
  assign pos_wide = (status == sle_pkg::ST_OK) ? 32'(i) : 32'd0;
  assign cnt_wide = 32'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // A result that drains while the next one is ready is reloaded in S_DONE instead.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op     <= s_tuser;
            val    <= s_tdata;
            i      <= '0;
            if (s_tuser == sle_pkg::OP_INSERT && count >= DEPTH_C) begin
              status <= sle_pkg::ST_FULL;
              state  <= S_DONE;
            end else if (s_tuser == sle_pkg::OP_INSERT || s_tuser == sle_pkg::OP_DELETE ||
                         s_tuser == sle_pkg::OP_SEARCH) begin
              status <= sle_pkg::ST_ABSENT;
              state  <= S_SCAN_RD;
            end else begin
              status <= sle_pkg::ST_ABSENT;
              state  <= S_DONE;
            end
          end
        end
        S_SCAN_RD: begin
          if (i == count) begin
            found <= 1'b0;
            state <= S_DECIDE;
          end else begin
            state <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (cmp.lt) begin
            i     <= i + ONE;
            state <= S_SCAN_RD;
          end else begin
            found <= cmp.eq;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          priority if (op == sle_pkg::OP_INSERT) begin
            status <= sle_pkg::ST_OK;
            j      <= count;
            state  <= (count > i) ? S_SH_RD : S_PUT;
          end else if (!found) begin
            status <= sle_pkg::ST_ABSENT;
            state  <= S_DONE;
          end else if (op == sle_pkg::OP_DELETE) begin
            status <= sle_pkg::ST_OK;
            j      <= i;
            if ((i + ONE) < count) begin
              state <= S_SH_RD;
            end else begin
              count <= count - ONE;
              state <= S_DONE;
            end
          end else begin
            status <= sle_pkg::ST_OK;
            state  <= S_DONE;
          end
        end
        S_SH_RD: begin
          state <= S_SH_WR;
        end
        S_SH_WR: begin
          if (op == sle_pkg::OP_INSERT) begin
            j     <= jm1;
            state <= (jm1 > i) ? S_SH_RD : S_PUT;
          end else begin
            j <= jp1;
            if ((jp1 + ONE) < count) begin
              state <= S_SH_RD;
            end else begin
              count <= count - ONE;
              state <= S_DONE;
            end
          end
        end
        S_PUT: begin
          count <= count + ONE;
          state <= S_DONE;
        end
        S_DONE: begin
          // The result register is loaded once it is empty or being drained.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= status;
            out_pos  <= pos_wide[3:0];
            out_cnt  <= cnt_wide[4:0];
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {7'd0, out_cnt, out_pos};

endmodule

// ----- tb/sorted_list_engine_top_tb.sv -----
// Self-checking testbench for the sorted list engine: stream stimulus, live list predictor.
module sorted_list_engine_top_tb;

  localparam int DEPTH = 16;

  // One command word as the sender sees it, and one predicted result word.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
  } list_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
    logic [4:0] entry_count;
  } list_result_t;

  // Unused opcode; the block must answer it as "not present" and leave the list alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] value
  logic [1:0]  s_tuser = '0;   // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [3:0] position, [8:4] entry_count, rest zero
  logic [1:0]  m_tuser;        // [1:0] status

  sorted_list_engine_top #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Commands waiting to be offered, and results predicted but not yet seen.
  list_cmd_t    pending_cmds[$];
  list_result_t expected_results[$];
  int           error_count = 0;

  // Shadow copy of the list: ascending signed values and the number held.
  logic signed [31:0] shadow_vals [DEPTH];
  int                 shadow_len = 0;

  // Applies one command to the shadow list and returns the result the block should give.
  // The scan stops at the first entry that is not below the value, so an insert lands
  // ahead of any equal entries and delete/search act on the first equal one.
  function automatic list_result_t apply_list_cmd(logic [1:0] op, logic signed [31:0] v);
    list_result_t r;
    int           idx;
    int           i;
    r.status   = sle_pkg::ST_ABSENT;
    r.position = '0;
    idx = 0;
    while (idx < shadow_len && shadow_vals[idx] < v) idx++;
    case (op)
      sle_pkg::OP_INSERT: begin
        if (shadow_len >= DEPTH) begin
          r.status = sle_pkg::ST_FULL;
        end else begin
          for (i = shadow_len; i > idx; i--) shadow_vals[i] = shadow_vals[i-1];
          shadow_vals[idx] = v;
          shadow_len++;
          r.status   = sle_pkg::ST_OK;
          r.position = idx[3:0];
        end
      end
      sle_pkg::OP_DELETE, sle_pkg::OP_SEARCH: begin
        if (idx < shadow_len && shadow_vals[idx] == v) begin
          r.status   = sle_pkg::ST_OK;
          r.position = idx[3:0];
          if (op == sle_pkg::OP_DELETE) begin
            for (i = idx; i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i+1];
            shadow_len--;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = shadow_len[4:0];
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps. A word that is
  // on the bus stays there until the block takes it.
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_list_cmd(s_tuser, s_tdata));
        void'(pending_cmds.pop_front());
      end
      if (s_tvalid && !s_tready) begin
        // Hold the current word.
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_cmds[0].value;
        s_tuser  <= pending_cmds[0].op;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: the stall pattern is redrawn periodically at random among always ready,
  // mostly ready and mostly stalled. Once, well into the run, it holds off for a
  // long stretch so the result sits unread and the block backs up its input.
  int rx_cycle  = 0;
  int rx_mode   = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
      if (rx_cycle == 3000) hold_left = 600;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: every result word taken is checked against the oldest prediction.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: status=%0d data=%h", m_tuser, m_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          error_count++;
        end
        if (m_tdata[3:0] !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, m_tdata[3:0]);
          error_count++;
        end
        if (m_tdata[8:4] !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, m_tdata[8:4]);
          error_count++;
        end
        if (m_tdata[15:9] !== 7'd0) begin
          $error("tdata padding: expected 0, got %h", m_tdata[15:9]);
          error_count++;
        end
      end
    end
  end

  task automatic queue_cmd(logic [1:0] op, logic [31:0] v);
    list_cmd_t c;
    c.op    = op;
    c.value = v;
    pending_cmds.push_back(c);
  endtask

  // Picks an opcode by weight; the three modes fill, drain or churn the list.
  function automatic logic [1:0] pick_op(int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return OP_UNUSED;
    case (mode)
      0: return (roll < 75) ? sle_pkg::OP_INSERT :
                (roll < 88) ? sle_pkg::OP_DELETE : sle_pkg::OP_SEARCH;
      1: return (roll < 20) ? sle_pkg::OP_INSERT :
                (roll < 70) ? sle_pkg::OP_DELETE : sle_pkg::OP_SEARCH;
      default: return (roll < 45) ? sle_pkg::OP_INSERT :
                      (roll < 72) ? sle_pkg::OP_DELETE : sle_pkg::OP_SEARCH;
    endcase
  endfunction

  initial begin
    logic [31:0] value_pool [6];
    logic [31:0] v;
    int          mode;
    int          roll;

    // Directed part: empty-list lookups, the unused opcode, the value extremes,
    // a run of equal entries, early-stopping misses and deletes at both ends.
    queue_cmd(sle_pkg::OP_SEARCH, 32'd5);
    queue_cmd(sle_pkg::OP_DELETE, 32'd5);
    queue_cmd(OP_UNUSED, 32'hffff_ffff);
    queue_cmd(sle_pkg::OP_INSERT, VAL_MAX);
    queue_cmd(sle_pkg::OP_INSERT, VAL_MIN);
    queue_cmd(sle_pkg::OP_INSERT, 32'd0);
    queue_cmd(sle_pkg::OP_INSERT, 32'hffff_ffff);
    queue_cmd(sle_pkg::OP_INSERT, 32'd0);
    queue_cmd(sle_pkg::OP_INSERT, 32'd0);
    queue_cmd(sle_pkg::OP_SEARCH, 32'd0);
    queue_cmd(sle_pkg::OP_SEARCH, 32'd3);
    queue_cmd(sle_pkg::OP_SEARCH, VAL_MAX);
    queue_cmd(sle_pkg::OP_SEARCH, VAL_MIN);
    queue_cmd(OP_UNUSED, 32'd0);
    queue_cmd(sle_pkg::OP_DELETE, 32'd0);
    queue_cmd(sle_pkg::OP_DELETE, VAL_MIN);
    queue_cmd(sle_pkg::OP_DELETE, VAL_MAX);
    queue_cmd(sle_pkg::OP_DELETE, 32'd9);
    queue_cmd(sle_pkg::OP_INSERT, 32'h5555_5555);
    queue_cmd(sle_pkg::OP_INSERT, 32'haaaa_aaaa);
    queue_cmd(sle_pkg::OP_SEARCH, 32'haaaa_aaaa);

    // Random part in chunks of 40. Each chunk has its own small pool of values so
    // that deletes and searches hit, equal entries pile up and the list fills.
    for (int chunk = 0; chunk < 20; chunk++) begin
      mode = $urandom_range(0, 2);
      foreach (value_pool[i]) begin
        if ($urandom_range(0, 1) == 0) value_pool[i] = $urandom_range(0, 20) - 10;
        else value_pool[i] = $urandom;
      end
      for (int n = 0; n < 40; n++) begin
        roll = $urandom_range(0, 9);
        if (roll < 7) v = value_pool[$urandom_range(0, 5)];
        else if (roll < 9) v = $urandom;
        else begin
          case ($urandom_range(0, 3))
            0:       v = VAL_MIN;
            1:       v = VAL_MAX;
            2:       v = 32'd0;
            default: v = 32'hffff_ffff;
          endcase
        end
        queue_cmd(pick_op(mode), v);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything sent and every predicted result seen, then a quiet
    // stretch longer than the slowest operation to catch stray result words.
    while (pending_cmds.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);

    if (expected_results.size() > 0) begin
      $error("%0d results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the long receiver hold-off.
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
